@@ hdl/tlbcr_pkg.sv @@
package tlbcr_pkg;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [1:0] STATUS_HIT   = 2'd0;
  localparam logic [1:0] STATUS_MISS  = 2'd1;
  localparam logic [1:0] STATUS_FILL  = 2'd2;
  localparam logic [1:0] STATUS_EVICT = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [31:0] virt_address;
    logic [31:0] frame_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] translated_address;
    logic [31:0] lookup_total;
    logic [31:0] insert_total;
  } rsp_t;

endpackage

@@ hdl/tlbcr_ram.sv @@
module tlbcr_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tlbcr_front.sv @@
module tlbcr_front #(
  parameter int OFFSET_WIDTH = 12,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  tlbcr_pkg::req_t                      in_data_i,
  output logic                                 pop_valid_o,
  input  logic                                 pop_ready_i,
  output logic                                 pop_op_o,
  output logic [ADDRESS_BITS-OFFSET_WIDTH-1:0] pop_vpage_o,
  output logic [ADDRESS_BITS-OFFSET_WIDTH-1:0] pop_ppage_o,
  output logic [OFFSET_WIDTH-1:0]              pop_offset_o
);

  localparam int PW = ADDRESS_BITS - OFFSET_WIDTH;
  localparam int QW = 1 + 2 * PW + OFFSET_WIDTH;

  logic [ADDRESS_BITS-1:0] vaddr;
  logic [ADDRESS_BITS-1:0] faddr;
  logic [QW-1:0]           item;
  logic [QW-1:0]           slot_q [2];
  logic                    wptr_q, wptr_d;
  logic                    rptr_q, rptr_d;
  logic [1:0]              count_q, count_d;
  logic                    push;
  logic                    pop;

  assign vaddr = ADDRESS_BITS'(in_data_i.virt_address);
  assign faddr = ADDRESS_BITS'(in_data_i.frame_address);
  assign item  = {in_data_i.operation, vaddr[ADDRESS_BITS-1:OFFSET_WIDTH],
                  faddr[ADDRESS_BITS-1:OFFSET_WIDTH], vaddr[OFFSET_WIDTH-1:0]};

  assign in_ready_o  = (count_q != 2'd2);
  assign pop_valid_o = (count_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_valid_o && pop_ready_i;

  assign {pop_op_o, pop_vpage_o, pop_ppage_o, pop_offset_o} = slot_q[rptr_q];

  always_comb begin
    wptr_d  = push ? ~wptr_q : wptr_q;
    rptr_d  = pop ? ~rptr_q : rptr_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

@@ hdl/tlbcr_back.sv @@
module tlbcr_back #(
  parameter int ENTRIES      = 16,
  parameter int OFFSET_WIDTH = 12,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 pop_valid_i,
  output logic                                 pop_ready_o,
  input  logic                                 pop_op_i,
  input  logic [ADDRESS_BITS-OFFSET_WIDTH-1:0] pop_vpage_i,
  input  logic [ADDRESS_BITS-OFFSET_WIDTH-1:0] pop_ppage_i,
  input  logic [OFFSET_WIDTH-1:0]              pop_offset_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tlbcr_pkg::rsp_t                      out_data_o
);

  localparam int PW = ADDRESS_BITS - OFFSET_WIDTH;
  localparam int IW = $clog2(ENTRIES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [ENTRIES-1:0]      valid_q, valid_d;
  logic [ENTRIES-1:0]      used_q, used_d;
  logic [PW-1:0]           vtag_q [ENTRIES];
  logic [IW-1:0]           hand_q, hand_d;
  logic [31:0]             lcnt_q, lcnt_d;
  logic [31:0]             icnt_q, icnt_d;
  logic [1:0]              status_q, status_d;
  logic                    hit_q, hit_d;
  logic [OFFSET_WIDTH-1:0] off_q, off_d;
  logic [PW-1:0]           vpage_q, vpage_d;
  logic [PW-1:0]           ppage_q, ppage_d;
  logic                    out_valid_q, out_valid_d;
  tlbcr_pkg::rsp_t         out_q, out_d;

  logic                    hit;
  logic [IW-1:0]           hit_idx;
  logic                    free;
  logic [IW-1:0]           free_idx;
  logic [IW-1:0]           hand_nxt;
  logic                    pop;
  logic                    out_free;
  logic                    tag_we;
  logic [IW-1:0]           tag_waddr;
  logic [PW-1:0]           tag_wdata;
  logic [PW-1:0]           ram_wdata;
  logic                    ram_re;
  logic [PW-1:0]           ram_rdata;
  logic [ADDRESS_BITS-1:0] paddr;

  assign pop_ready_o = (state_q == S_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign hand_nxt    = (hand_q == IW'(ENTRIES - 1)) ? '0 : hand_q + 1'b1;
  assign paddr       = {ram_rdata, off_q};

  // lowest matching and lowest free entry
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (vtag_q[i] == pop_vpage_i)) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid_q[i]) begin
        free     = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    used_d      = used_q;
    hand_d      = hand_q;
    lcnt_d      = lcnt_q;
    icnt_d      = icnt_q;
    status_d    = status_q;
    hit_d       = hit_q;
    off_d       = off_q;
    vpage_d     = vpage_q;
    ppage_d     = ppage_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    tag_we      = 1'b0;
    tag_waddr   = free_idx;
    tag_wdata   = pop_vpage_i;
    ram_wdata   = pop_ppage_i;
    ram_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          off_d = pop_offset_i;
          if (pop_op_i == tlbcr_pkg::OP_LOOKUP) begin
            lcnt_d = lcnt_q + 32'd1;
            hit_d  = hit;
            if (hit) begin
              used_d[hit_idx] = 1'b1;
              ram_re          = 1'b1;
              status_d        = tlbcr_pkg::STATUS_HIT;
              state_d         = S_READ;
            end else begin
              status_d = tlbcr_pkg::STATUS_MISS;
              state_d  = S_EMIT;
            end
          end else begin
            icnt_d = icnt_q + 32'd1;
            hit_d  = 1'b0;
            if (free) begin
              tag_we           = 1'b1;
              valid_d[free_idx] = 1'b1;
              used_d[free_idx]  = 1'b0;
              status_d         = tlbcr_pkg::STATUS_FILL;
              state_d          = S_EMIT;
            end else begin
              vpage_d  = pop_vpage_i;
              ppage_d  = pop_ppage_i;
              status_d = tlbcr_pkg::STATUS_EVICT;
              state_d  = S_SWEEP;
            end
          end
        end
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_SWEEP: begin
        tag_waddr = hand_q;
        tag_wdata = vpage_q;
        ram_wdata = ppage_q;
        hand_d    = hand_nxt;
        if (used_q[hand_q]) begin
          used_d[hand_q] = 1'b0;
        end else begin
          tag_we          = 1'b1;
          valid_d[hand_q] = 1'b1;
          state_d         = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_d.status             = status_q;
          out_d.translated_address = hit_q ? 32'(paddr) : 32'd0;
          out_d.lookup_total       = lcnt_q;
          out_d.insert_total       = icnt_q;
          state_d                  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  tlbcr_ram #(
    .WIDTH (PW),
    .DEPTH (ENTRIES)
  ) u_ppage_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (hit_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      vtag_q[tag_waddr] <= tag_wdata;
    end
    status_q <= status_d;
    hit_q    <= hit_d;
    off_q    <= off_d;
    vpage_q  <= vpage_d;
    ppage_q  <= ppage_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      used_q      <= '0;
      hand_q      <= '0;
      lcnt_q      <= 32'd0;
      icnt_q      <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      used_q      <= used_d;
      hand_q      <= hand_d;
      lcnt_q      <= lcnt_d;
      icnt_q      <= icnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/tlb_clock_replacement.sv @@
// fully associative tlb with clock replacement
// in channel: in_valid_i/in_ready_o with in_data_i, op 0 looks up, op 1 inserts
// out channel: out_valid_o/out_ready_i with out_data_o, one result per request
// requests enter a two-slot queue, the back end runs them one at a time
// from input transfer to output valid a request passes the queue; a lookup
// hit then waits in S_READ for the registered read of the physical page ram,
// a lookup miss or free-entry insert goes straight to S_EMIT, and a clock
// eviction first sweeps, one entry examined per cycle, to a clear used bit
// the back end takes a new request only after it has emitted the last one
// reset clears all valid and used bits, the clock hand and both counters
// a stalled receiver holds the output register; the back end waits to emit,
// the queue fills and in_ready_o drops after two more requests
module tlb_clock_replacement #(
  parameter int ENTRIES      = 16,
  parameter int OFFSET_WIDTH = 12,
  parameter int ADDRESS_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tlbcr_pkg::req_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tlbcr_pkg::rsp_t out_data_o
);

  localparam int PW = ADDRESS_BITS - OFFSET_WIDTH;

  logic                    pop_valid;
  logic                    pop_ready;
  logic                    pop_op;
  logic [PW-1:0]           pop_vpage;
  logic [PW-1:0]           pop_ppage;
  logic [OFFSET_WIDTH-1:0] pop_offset;

  tlbcr_front #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op),
    .pop_vpage_o  (pop_vpage),
    .pop_ppage_o  (pop_ppage),
    .pop_offset_o (pop_offset)
  );

  tlbcr_back #(
    .ENTRIES      (ENTRIES),
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_op_i     (pop_op),
    .pop_vpage_i  (pop_vpage),
    .pop_ppage_i  (pop_ppage),
    .pop_offset_i (pop_offset),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // only a hit carries an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != tlbcr_pkg::STATUS_HIT)
    |-> (out_data_o.translated_address == 32'd0))
    else $error("non-hit result with nonzero address");

  // a full queue always offers work to the back end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> pop_valid)
    else $error("queue full but nothing offered");

  // a request taken while a result is stuck does not overwrite the held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && pop_ready |=> !(out_valid_o && $past(out_valid_o && !out_ready_i)
    && $changed(out_data_o)))
    else $error("result overwritten while stalled");

endmodule
